/* src/stok_pkg.sv */
// Shared types and token kind codes for the source tokenizer.
package stok_pkg;

	typedef logic [5:0] kind_t;

	localparam kind_t K_EOF     = 6'd0;
	localparam kind_t K_INVALID = 6'd1;
	localparam kind_t K_IDENT   = 6'd2;
	localparam kind_t K_STRING  = 6'd3;
	localparam kind_t K_INT     = 6'd4;
	localparam kind_t K_FLOAT   = 6'd5;
	localparam kind_t K_KEYWORD = 6'd37;
	localparam kind_t K_LAST    = 6'd43;

	// One token as it leaves the block.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] start_pos;
		logic [31:0] end_pos;
		logic        last;
	} token_t;

	// Tokens produced by one byte, packed from tok0 upward.
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} push_t;

endpackage

/* src/stok_scan.sv */
// Scanner: input register, next-state logic and token generation.
module stok_scan import stok_pkg::*; #(
	parameter int POS_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] text_byte,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       room,
	output push_t      push
);

	typedef enum logic [2:0] {
		M_IDLE, M_COMMENT, M_IDENT, M_NUMBER, M_STRING, M_OPER
	} mode_t;

	typedef logic [3:0] opi_t;
	localparam opi_t OP_STAR     = 4'd4;
	localparam opi_t OP_STARSTAR = 4'd9;

	typedef struct packed {
		kind_t      eq_kind;
		logic [7:0] alt_char;
		kind_t      alt_kind;
		kind_t      single_kind;
	} op_row_t;

	typedef logic [POS_WIDTH-1:0] pos_t;

	// Operator table: kinds for "x=", the alternate second byte, and plain "x".
	function automatic op_row_t op_row(input opi_t idx);
		op_row_t r;
		r = '{eq_kind: 6'd0, alt_char: 8'd0, alt_kind: 6'd0, single_kind: 6'd0};
		unique case (idx)
			4'd0: r = '{6'd12, 8'd0, 6'd0, 6'd13};
			4'd1: r = '{6'd14, 8'd0, 6'd0, 6'd15};
			4'd2: r = '{6'd16, 8'd0, 6'd0, 6'd17};
			4'd3: r = '{6'd18, ">",  6'd19, 6'd20};
			4'd4: r = '{6'd23, 8'd0, 6'd0, 6'd24};
			4'd5: r = '{6'd25, 8'd0, 6'd0, 6'd26};
			4'd6: r = '{6'd27, 8'd0, 6'd0, 6'd28};
			4'd7: r = '{6'd29, "-",  6'd30, 6'd31};
			4'd8: r = '{6'd32, 8'd0, 6'd0, 6'd33};
			4'd9: r = '{6'd21, 8'd0, 6'd0, 6'd22};
			default: r = '{6'd0, 8'd0, 6'd0, 6'd0};
		endcase
		return r;
	endfunction

	// Keyword text, left aligned and zero padded to eight bytes.
	function automatic logic [63:0] kw_text(input logic [2:0] k);
		logic [63:0] t;
		t = '0;
		unique case (k)
			3'd0: t = {"if", 48'd0};
			3'd1: t = {"else", 32'd0};
			3'd2: t = {"while", 24'd0};
			3'd3: t = {"break", 24'd0};
			3'd4: t = "continue";
			3'd5: t = {"fn", 48'd0};
			3'd6: t = {"return", 16'd0};
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] kw_len(input logic [2:0] k);
		logic [3:0] n;
		n = 4'd0;
		unique case (k)
			3'd0: n = 4'd2;
			3'd1: n = 4'd4;
			3'd2: n = 4'd5;
			3'd3: n = 4'd5;
			3'd4: n = 4'd8;
			3'd5: n = 4'd2;
			3'd6: n = 4'd6;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// Keywords that still match after byte c lands at index i.
	function automatic logic [6:0] kw_keep(input logic [3:0] i, input logic [7:0] c);
		logic [6:0]  m;
		logic [63:0] t;
		m = '0;
		for (int k = 0; k < 7; k++) begin
			t = kw_text(3'(k));
			m[k] = (i < kw_len(3'(k))) && (t[8*(7 - i[2:0]) +: 8] == c);
		end
		return m;
	endfunction

	// Input register
	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       fire;
	logic       accept;

	// Scanner state
	mode_t      mode_q;
	opi_t       op_q;
	pos_t       pos_q;
	pos_t       pstart_q;
	logic       dq_q;
	logic       esc_q;
	logic       pt_q;
	logic [3:0] len_q;
	logic [6:0] cand_q;

	mode_t      n_mode;
	opi_t       n_op;
	pos_t       n_pos;
	pos_t       n_pstart;
	logic       n_dq;
	logic       n_esc;
	logic       n_pt;
	logic [3:0] n_len;
	logic [6:0] n_cand;

	logic [7:0] c;
	pos_t       p;
	pos_t       p1;
	logic       is_alpha;
	logic       is_num;

	// Idle-byte handling
	logic       i_emit;
	kind_t      i_kind;
	pos_t       i_end;
	mode_t      i_mode;
	opi_t       i_op;
	logic       i_eof;
	logic       i_ps_we;
	pos_t       i_ps;
	logic       i_str;
	logic       i_ident;
	logic       i_num;

	// Pending-token result
	logic       e0;
	kind_t      k0;
	pos_t       end0;
	logic       use_idle;
	logic       emit1;
	kind_t      ident_kind;
	op_row_t    row;

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	assign c  = byte_s1;
	assign p  = pos_q;
	assign p1 = pos_q + 1'b1;
	assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	assign is_num   = c >= "0" && c <= "9";
	assign row      = op_row(op_q);

	// Hold the byte until the scanner takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
		end
	end

	// Classify a byte seen between tokens.
	always_comb begin
		i_emit  = 1'b0;
		i_kind  = K_INVALID;
		i_end   = p1;
		i_mode  = M_IDLE;
		i_op    = '0;
		i_eof   = 1'b0;
		i_ps_we = 1'b0;
		i_ps    = p;
		i_str   = 1'b0;
		i_ident = 1'b0;
		i_num   = 1'b0;
		priority if (c == " " || c == "\t" || c == "\n" || c == "\r") begin
		end else if (c == 8'd0) begin
			i_emit = 1'b1;
			i_kind = K_EOF;
			i_end  = p;
			i_eof  = 1'b1;
		end else if (c == "#") begin
			i_mode = M_COMMENT;
		end else if (c == "(" || c == ")" || c == "{" || c == "}" || c == "[" || c == "]"
				|| c == "." || c == "," || c == ":") begin
			i_emit = 1'b1;
			priority case (c)
				"(":     i_kind = 6'd6;
				")":     i_kind = 6'd7;
				"{":     i_kind = 6'd8;
				"}":     i_kind = 6'd9;
				"[":     i_kind = 6'd10;
				"]":     i_kind = 6'd11;
				".":     i_kind = 6'd34;
				",":     i_kind = 6'd35;
				default: i_kind = 6'd36;
			endcase
		end else if (c == "=" || c == "!" || c == "+" || c == "-" || c == "*" || c == "/"
				|| c == "%" || c == "<" || c == ">") begin
			i_mode  = M_OPER;
			i_ps_we = 1'b1;
			priority case (c)
				"=":     i_op = 4'd0;
				"!":     i_op = 4'd1;
				"+":     i_op = 4'd2;
				"-":     i_op = 4'd3;
				"*":     i_op = OP_STAR;
				"/":     i_op = 4'd5;
				"%":     i_op = 4'd6;
				"<":     i_op = 4'd7;
				default: i_op = 4'd8;
			endcase
		end else if (c == "\"" || c == "'") begin
			i_mode  = M_STRING;
			i_str   = 1'b1;
			i_ps_we = 1'b1;
			i_ps    = p1;
		end else if (is_alpha) begin
			i_mode  = M_IDENT;
			i_ident = 1'b1;
			i_ps_we = 1'b1;
		end else if (is_num) begin
			i_mode  = M_NUMBER;
			i_num   = 1'b1;
			i_ps_we = 1'b1;
		end else begin
			i_emit = 1'b1;
		end
	end

	// Resolve an identifier against the keywords still in the running.
	always_comb begin
		ident_kind = K_IDENT;
		for (int k = 0; k < 7; k++) begin
			if (cand_q[k] && len_q == kw_len(3'(k))) begin
				ident_kind = K_KEYWORD + 6'(k);
			end
		end
	end

	// Advance the pending token; fall back to idle handling for a byte that closes it but is not part of it.
	always_comb begin
		e0       = 1'b0;
		k0       = K_INVALID;
		end0     = p;
		use_idle = 1'b0;
		n_mode   = mode_q;
		n_op     = op_q;
		n_pstart = pstart_q;
		n_dq     = dq_q;
		n_esc    = esc_q;
		n_pt     = pt_q;
		n_len    = len_q;
		n_cand   = cand_q;
		unique case (mode_q)
			M_COMMENT: begin
				use_idle = (c == 8'd0) || (c == "\n");
			end
			M_IDENT: begin
				if (is_alpha || is_num) begin
					n_cand = cand_q & kw_keep(len_q, c);
					n_len  = (len_q == 4'd15) ? len_q : len_q + 4'd1;
				end else begin
					e0       = 1'b1;
					k0       = ident_kind;
					use_idle = 1'b1;
				end
			end
			M_NUMBER: begin
				if (is_alpha || is_num || c == ".") begin
					if (c == ".") begin
						n_pt = 1'b1;
					end
				end else begin
					e0       = 1'b1;
					k0       = pt_q ? K_FLOAT : K_INT;
					use_idle = 1'b1;
				end
			end
			M_STRING: begin
				priority if (c == 8'd0 || (!esc_q && c == "\n")) begin
					n_esc    = 1'b0;
					e0       = 1'b1;
					k0       = K_INVALID;
					use_idle = 1'b1;
				end else if (esc_q) begin
					n_esc = 1'b0;
				end else if (c == "\\") begin
					n_esc = 1'b1;
				end else if (c == (dq_q ? 8'h22 : 8'h27)) begin
					e0     = 1'b1;
					k0     = K_STRING;
					n_mode = M_IDLE;
				end else begin
				end
			end
			M_OPER: begin
				priority if (op_q == OP_STAR && c == "*") begin
					n_op = OP_STARSTAR;
				end else if (c == "=") begin
					e0     = 1'b1;
					k0     = row.eq_kind;
					end0   = p1;
					n_mode = M_IDLE;
				end else if (row.alt_char != 8'd0 && c == row.alt_char) begin
					e0     = 1'b1;
					k0     = row.alt_kind;
					end0   = p1;
					n_mode = M_IDLE;
				end else begin
					e0       = 1'b1;
					k0       = row.single_kind;
					use_idle = 1'b1;
				end
			end
			default: begin
				use_idle = 1'b1;
			end
		endcase

		if (use_idle) begin
			n_mode = i_mode;
			if (i_mode == M_OPER) begin
				n_op = i_op;
			end
			if (i_ps_we) begin
				n_pstart = i_ps;
			end
			if (i_str) begin
				n_dq  = (c == "\"");
				n_esc = 1'b0;
			end
			if (i_ident) begin
				n_len  = 4'd1;
				n_cand = kw_keep(4'd0, c);
			end
			if (i_num) begin
				n_pt = 1'b0;
			end
		end

		n_pos = (use_idle && i_eof) ? '0 : p1;
	end

	assign emit1 = use_idle && i_emit;

	// Pack the words for the result queue, pending token first.
	always_comb begin
		push.count = 2'd0;
		push.tok0  = '{kind: i_kind, start_pos: 32'(p), end_pos: 32'(i_end), last: 1'b1};
		push.tok1  = push.tok0;
		if (fire) begin
			push.count = {1'b0, e0} + {1'b0, emit1};
		end
		if (e0) begin
			push.tok0 = '{kind: k0, start_pos: 32'(pstart_q), end_pos: 32'(end0),
				last: !emit1};
		end
	end

	// Hold scanner state; advance on every processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			op_q     <= '0;
			pos_q    <= '0;
			pstart_q <= '0;
			dq_q     <= 1'b0;
			esc_q    <= 1'b0;
			pt_q     <= 1'b0;
			len_q    <= '0;
			cand_q   <= '1;
		end else if (fire) begin
			mode_q   <= n_mode;
			op_q     <= n_op;
			pos_q    <= n_pos;
			pstart_q <= n_pstart;
			dq_q     <= n_dq;
			esc_q    <= n_esc;
			pt_q     <= n_pt;
			len_q    <= n_len;
			cand_q   <= n_cand;
		end
	end

endmodule

/* src/stok_fifo.sv */
// Four-entry result queue: takes up to two words a cycle, gives one unless out_stall is high.
module stok_fifo import stok_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        room,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [31:0] token_start,
	output logic [31:0] token_end,
	output logic        last_of_run
);

	token_t     mem [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       pop;
	token_t     head;

	assign out_valid = cnt_q != 3'd0;
	assign pop       = out_valid && !out_stall;
	assign room      = cnt_q <= 3'd2;
	assign head      = mem[rd_q];

	assign token_kind  = head.kind;
	assign token_start = head.start_pos;
	assign token_end   = head.end_pos;
	assign last_of_run = head.last;

	// Write the new words at the tail.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.tok0;
		end
		if (push.count == 2'd2) begin
			mem[wr_q + 2'd1] <= push.tok1;
		end
	end

	// Advance pointers and the fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.count;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.count} - {2'b0, pop};
		end
	end

endmodule

/* src/source_tokenizer_top.sv */
// Streaming tokenizer: one source byte in per word, tokens out per word.
// A token passes the input register and is written into the result queue before it leaves.
// Throughput: one byte per cycle; a byte yields zero, one or two tokens, and the
// four-entry result queue stalls input when fewer than two slots are free.
// Reset (arst_n low, asynchronous): scanner idle, position zero, queue empty.
module source_tokenizer_top import stok_pkg::*; #(
	parameter int POS_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [31:0] token_start,
	output logic [31:0] token_end,
	output logic        last_of_run
);

	push_t push;
	logic  room;

	stok_scan #(
		.POS_WIDTH (POS_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_byte (text_byte),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.room      (room),
		.push      (push)
	);

	stok_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.room        (room),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_end   (token_end),
		.last_of_run (last_of_run)
	);

endmodule

/* src/stok_checker.sv */
// Port-level checks on the tokenizer output stream.
module stok_checker import stok_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [5:0]  token_kind,
	input logic [31:0] token_start,
	input logic [31:0] token_end,
	input logic        last_of_run
);

	// A stalled word stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// A stalled word does not change.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(token_kind) && $stable(token_start)
			&& $stable(token_end) && $stable(last_of_run))
		else $error("output word changed while stalled");

	// End of text is an empty range and always closes its run.
	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_EOF |-> token_start == token_end && last_of_run)
		else $error("eof token malformed");

	// Only defined kinds leave the block.
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_kind <= K_LAST)
		else $error("token kind out of range");

endmodule

bind source_tokenizer_top stok_checker u_stok_checker (.*);
